>>> design/ptr_pkg.sv
// Package for the page text renderer: field codes, microcode control word,
// the sequencer program and the 5x7 font table.
// No dependencies.
`timescale 1ns / 1ps

package ptr_pkg;

  localparam int GLYPH_COLUMNS = 5;
  localparam int COL_W         = 3;
  localparam int UPC_W         = 3;
  localparam int GLYPH_COUNT   = 95;
  localparam int GLYPH_IDX_W   = 7;
  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd126;
  localparam logic [7:0] FALLBACK_CODE = 8'd63;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_DRAW  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_ADVANCE = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLR,
    OP_RDBYTE,
    OP_EVAL,
    OP_RD_A,
    OP_RD_B
  } uop_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_CLR_MORE,
    JC_DRAW,
    JC_COL_MORE
  } jcond_e;

  typedef struct packed {
    uop_e             op;
    jcond_e           jc;
    logic [UPC_W-1:0] target;
    logic             fin;
  } uword_t;

  localparam logic [UPC_W-1:0] UPC_CLEAR = 3'd0;
  localparam logic [UPC_W-1:0] UPC_READ  = 3'd1;
  localparam logic [UPC_W-1:0] UPC_IDLE  = 3'd2;
  localparam logic [UPC_W-1:0] UPC_DRAW  = 3'd3;
  localparam logic [UPC_W-1:0] UPC_COL   = 3'd4;
  localparam logic [UPC_W-1:0] UPC_COL_B = 3'd5;

  // A taken jump wins over fin; fin ends the program when no jump is taken.
  function automatic uword_t ucode(logic [UPC_W-1:0] upc);
    uword_t w;
    w = '{op: OP_NOP, jc: JC_NONE, target: UPC_IDLE, fin: 1'b1};
    case (upc)
      UPC_CLEAR: w = '{op: OP_CLR,    jc: JC_CLR_MORE, target: UPC_CLEAR, fin: 1'b1};
      UPC_READ:  w = '{op: OP_RDBYTE, jc: JC_NONE,     target: UPC_IDLE,  fin: 1'b0};
      UPC_IDLE:  w = '{op: OP_NOP,    jc: JC_NONE,     target: UPC_IDLE,  fin: 1'b1};
      UPC_DRAW:  w = '{op: OP_EVAL,   jc: JC_DRAW,     target: UPC_COL,   fin: 1'b1};
      UPC_COL:   w = '{op: OP_RD_A,   jc: JC_NONE,     target: UPC_IDLE,  fin: 1'b0};
      UPC_COL_B: w = '{op: OP_RD_B,   jc: JC_COL_MORE, target: UPC_COL,   fin: 1'b1};
      default:   w = '{op: OP_NOP,    jc: JC_NONE,     target: UPC_IDLE,  fin: 1'b1};
    endcase
    return w;
  endfunction

  typedef logic [0:GLYPH_COLUMNS-1][7:0] glyph_t;

  // Leftmost byte is glyph column 0; bit 0 is the top pixel.
  localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
    40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
    40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
    40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
    40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
    40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
    40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
    40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
    40'h0003070800, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
    40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
    40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
    40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
    40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
    40'h0000770000, 40'h0041360800, 40'h08082A1C08
  };

endpackage

>>> design/page_text_renderer.sv
// Page text renderer top level: microcoded sequencer, cursor logic and the
// framebuffer datapath. Depends on ptr_pkg and ptr_ram.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Its single result is
// shown on the result ports for one cycle with done_o high, and the receiver
// cannot stall it. A draw item that places a character runs one evaluation
// step, then two steps per glyph column, since every column needs a
// read-modify-write of up to two framebuffer bytes through the one read port
// and one write port of the framebuffer RAM. A refused character takes only
// the evaluation step. A read item runs a byte-read step and then an idle
// step, and an unused function code only the idle step. A clear item sweeps
// the framebuffer one byte per cycle, MAX_WIDTH*MAX_PAGES bytes in all (1024
// by default), and its result follows the sweep. After reset the same
// clearing pass runs with busy high and without a result; configuration
// writes are taken at any time.
module page_text_renderer #(
  parameter int MAX_WIDTH        = 128,
  parameter int MAX_PAGES        = 8,
  parameter int MAX_STRING_CHARS = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func_i,
  input  logic [7:0] char_code_i,
  input  logic       first_i,
  input  logic [7:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [2:0] read_page_i,
  input  logic [6:0] read_column_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic [7:0] cursor_x_o,
  output logic [7:0] cursor_y_o,
  output logic       drawn_o,
  output logic       string_ended_o
);

  import ptr_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CH_W   = $clog2(MAX_STRING_CHARS + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [7:0]       panel_width_q;
  logic [6:0]       panel_height_q;
  logic [2:0]       char_advance_q;

  logic             busy_q, busy_d;
  logic             silent_q, silent_d;
  logic [UPC_W-1:0] upc_q, upc_d;
  logic             done_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [COL_W-1:0] col_q;

  logic [7:0]       cursor_col_q;
  logic [7:0]       cursor_row_q;
  logic [CH_W-1:0]  chars_q;
  logic             ended_q;
  logic             drawn_q;
  logic [7:0]       read_data_q;

  func_e            func_q;
  logic [7:0]       code_q;
  logic [2:0]       rpage_q;
  logic [6:0]       rcol_q;
  logic [7:0]       gx_q;
  logic [7:0]       gy_q;
  logic             gvis_q;
  glyph_t           glyph_q;

  logic             stage_vld_q;
  logic [ADDR_W-1:0] stage_addr_q;
  logic [7:0]       stage_mask_q;

  logic             accept;
  uword_t           uw;
  uop_e             op;
  logic             jump;
  logic             fin_now;

  logic [8:0]       eff_w;
  logic [4:0]       eff_pages;
  logic [7:0]       eff_h;
  logic             refuse;
  logic             draw_now;
  logic [7:0]       ncol;
  logic [9:0]       w_minus;
  logic             wrap;
  logic [7:0]       col_f;
  logic [7:0]       row_f;
  logic [CH_W-1:0]  chars_inc;
  logic             end_f;
  logic [GLYPH_IDX_W-1:0] gidx;

  logic [7:0]       gbyte;
  logic [8:0]       cx;
  logic             col_ok;
  logic [15:0]      shifted;
  logic             spill;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [ADDR_W-1:0] addr_rd;
  logic             rd_ok;

  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // Sequencer.
  assign uw = ucode(upc_q);
  assign op = busy_q ? uw.op : OP_NOP;

  always_comb begin
    case (uw.jc)
      JC_CLR_MORE: jump = (clr_cnt_q != LAST_ADDR);
      JC_DRAW:     jump = draw_now;
      JC_COL_MORE: jump = (col_q != COL_W'(GLYPH_COLUMNS - 1));
      default:     jump = 1'b0;
    endcase
  end

  assign fin_now = busy_q && !jump && uw.fin;

  always_comb begin
    busy_d   = busy_q;
    upc_d    = upc_q;
    silent_d = silent_q;
    if (!busy_q) begin
      if (accept) begin
        busy_d = 1'b1;
        case (func_e'(func_i))
          FUNC_CLEAR: upc_d = UPC_CLEAR;
          FUNC_DRAW:  upc_d = UPC_DRAW;
          FUNC_READ:  upc_d = UPC_READ;
          default:    upc_d = UPC_IDLE;
        endcase
      end
    end else if (jump) begin
      upc_d = uw.target;
    end else if (uw.fin) begin
      busy_d   = 1'b0;
      silent_d = 1'b0;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  // String and cursor decisions for the evaluation step.
  always_comb begin
    eff_w     = ({1'b0, panel_width_q} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH)
                                                        : {1'b0, panel_width_q};
    eff_pages = ({1'b0, panel_height_q[6:3]} > 5'(MAX_PAGES)) ? 5'(MAX_PAGES)
                                                              : {1'b0, panel_height_q[6:3]};
    eff_h     = {eff_pages, 3'b000};
    refuse    = (code_q == 8'd0) || (32'(chars_q) >= MAX_STRING_CHARS)
                || ({1'b0, cursor_col_q} >= eff_w);
    draw_now  = !ended_q && !refuse;
    ncol      = cursor_col_q + {5'd0, char_advance_q};
    w_minus   = {1'b0, eff_w} - 10'd5;
    wrap      = $signed({2'b00, ncol}) >= $signed(w_minus);
    col_f     = wrap ? 8'd0 : ncol;
    row_f     = wrap ? cursor_row_q + 8'd8 : cursor_row_q;
    chars_inc = chars_q + 1'b1;
    end_f     = (wrap && (row_f >= eff_h)) || (32'(chars_inc) >= MAX_STRING_CHARS)
                || ({1'b0, col_f} >= eff_w);
    gidx      = ((code_q >= FIRST_CODE) && (code_q <= LAST_CODE))
                ? GLYPH_IDX_W'(code_q - FIRST_CODE)
                : GLYPH_IDX_W'(FALLBACK_CODE - FIRST_CODE);
  end

  // Framebuffer datapath.
  always_comb begin
    gbyte   = glyph_q[col_q];
    cx      = {1'b0, gx_q} + {6'd0, col_q};
    col_ok  = gvis_q && (cx < eff_w);
    shifted = {8'd0, gbyte} << gy_q[2:0];
    spill   = (gy_q[2:0] != 3'd0) && (({1'b0, gy_q[7:3]} + 6'd1) < {1'b0, eff_pages});
    addr_a  = ADDR_W'(32'(gy_q[7:3]) * MAX_WIDTH + 32'(cx));
    addr_b  = ADDR_W'((32'(gy_q[7:3]) + 32'd1) * MAX_WIDTH + 32'(cx));
    addr_rd = ADDR_W'(32'(rpage_q) * MAX_WIDTH + 32'(rcol_q));
    rd_ok   = (32'(rpage_q) < MAX_PAGES) && (32'(rcol_q) < MAX_WIDTH);
  end

  always_comb begin
    case (op)
      OP_RDBYTE: ram_raddr = addr_rd;
      OP_RD_B:   ram_raddr = addr_b;
      default:   ram_raddr = addr_a;
    endcase
    if (op == OP_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = 8'd0;
    end else begin
      ram_we    = stage_vld_q;
      ram_waddr = stage_addr_q;
      ram_wdata = ram_rdata | stage_mask_q;
    end
  end

  ptr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q  <= 8'd128;
      panel_height_q <= 7'd64;
      char_advance_q <= 3'd6;
      busy_q         <= 1'b1;
      silent_q       <= 1'b1;
      upc_q          <= UPC_CLEAR;
      done_q         <= 1'b0;
      clr_cnt_q      <= '0;
      col_q          <= '0;
      cursor_col_q   <= 8'd0;
      cursor_row_q   <= 8'd0;
      chars_q        <= '0;
      ended_q        <= 1'b1;
      drawn_q        <= 1'b0;
      stage_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WIDTH:   panel_width_q  <= cfg_wdata_i;
          CFG_HEIGHT:  panel_height_q <= cfg_wdata_i[6:0];
          CFG_ADVANCE: char_advance_q <= cfg_wdata_i[2:0];
          default:     ;
        endcase
      end
      busy_q   <= busy_d;
      silent_q <= silent_d;
      upc_q    <= upc_d;
      done_q   <= fin_now && !silent_q;

      if (accept) begin
        drawn_q <= 1'b0;
        if ((func_e'(func_i) == FUNC_DRAW) && first_i) begin
          cursor_col_q <= start_x_i;
          cursor_row_q <= start_y_i;
          chars_q      <= '0;
          ended_q      <= 1'b0;
        end
      end

      if (op == OP_CLR) begin
        clr_cnt_q <= (clr_cnt_q == LAST_ADDR) ? '0 : clr_cnt_q + 1'b1;
      end

      if (op == OP_EVAL) begin
        col_q <= '0;
        if (!ended_q) begin
          if (refuse) begin
            ended_q <= 1'b1;
          end else begin
            drawn_q      <= 1'b1;
            chars_q      <= chars_inc;
            cursor_col_q <= col_f;
            cursor_row_q <= row_f;
            ended_q      <= end_f;
          end
        end
      end else if (op == OP_RD_B) begin
        col_q <= col_q + 1'b1;
      end

      case (op)
        OP_RD_A: stage_vld_q <= col_ok;
        OP_RD_B: stage_vld_q <= col_ok && spill;
        default: stage_vld_q <= 1'b0;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_e'(func_i);
      code_q  <= char_code_i;
      rpage_q <= read_page_i;
      rcol_q  <= read_column_i;
    end
    if (op == OP_EVAL) begin
      gx_q    <= cursor_col_q;
      gy_q    <= cursor_row_q;
      gvis_q  <= ({1'b0, cursor_col_q} < eff_w) && (cursor_row_q < eff_h);
      glyph_q <= GLYPH_ROM[gidx];
    end
    if (op == OP_RD_B) begin
      stage_addr_q <= addr_b;
      stage_mask_q <= shifted[15:8];
    end else begin
      stage_addr_q <= addr_a;
      stage_mask_q <= shifted[7:0];
    end
    if (fin_now) begin
      read_data_q <= ((func_q == FUNC_READ) && rd_ok) ? ram_rdata : 8'd0;
    end
  end

  assign done_o         = done_q;
  assign read_data_o    = read_data_q;
  assign cursor_x_o     = cursor_col_q;
  assign cursor_y_o     = cursor_row_q;
  assign drawn_o        = drawn_q;
  assign string_ended_o = ended_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result strobe while the sequencer is busy.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe lasted more than one cycle.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("Accepted transaction did not start the sequencer.");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_CLR) |-> !stage_vld_q)
    else $error("Glyph write pending during a clearing sweep.");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((op == OP_RD_A) || (op == OP_RD_B)) |-> (32'(col_q) < GLYPH_COLUMNS))
    else $error("Glyph column counter out of range.");

endmodule

>>> design/ptr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ptr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/tb.sv
// Self-checking testbench for page_text_renderer: drives characters, reads and
// clears through the start/busy port and predicts every result in a scoreboard.
// Depends on ptr_pkg and page_text_renderer.
`timescale 1ns / 1ps

module tb;
  import ptr_pkg::*;

  localparam int FRAME_COLS   = 128;
  localparam int FRAME_PAGES  = 8;
  localparam int STRING_LIMIT = 26;
  localparam int GLYPH_W      = 5;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 240;
  localparam int PHASE_WIDTH   [PHASES] = '{128, 1, 128, 37, 64, 255, 100, 8};
  localparam int PHASE_HEIGHT  [PHASES] = '{64, 8, 8, 24, 64, 127, 43, 16};
  localparam int PHASE_ADVANCE [PHASES] = '{6, 5, 5, 6, 5, 6, 5, 6};

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] cursor_x;
    logic [7:0] cursor_y;
    logic       drawn;
    logic       string_ended;
  } render_result_t;

  class render_scoreboard;
    logic [7:0]     frame_bytes [FRAME_COLS*FRAME_PAGES];
    logic [39:0]    glyph_cols [95];
    int             width_reg, height_reg, advance_reg;
    int             cursor_col, cursor_row, chars_taken;
    bit             string_done;
    render_result_t pending_results [$];
    int unsigned    mismatch_count;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      width_reg = 128;
      height_reg = 64;
      advance_reg = 6;
      cursor_col = 0;
      cursor_row = 0;
      chars_taken = 0;
      string_done = 1'b1;
      mismatch_count = 0;
      glyph_cols = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
        40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
        40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
        40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
        40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
        40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
        40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
        40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
        40'h0003070800, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
        40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
        40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
        40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
        40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
        40'h0000770000, 40'h0041360800, 40'h08082A1C08
      };
    endfunction

    function int eff_width();
      return (width_reg > FRAME_COLS) ? FRAME_COLS : width_reg;
    endfunction

    function int eff_pages();
      return ((height_reg >> 3) > FRAME_PAGES) ? FRAME_PAGES : (height_reg >> 3);
    endfunction

    function void set_register(cfg_idx_e idx, logic [7:0] value);
      case (idx)
        CFG_WIDTH:   width_reg = int'(value);
        CFG_HEIGHT:  height_reg = int'(value[6:0]);
        CFG_ADVANCE: advance_reg = int'(value[2:0]);
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted transaction and queues it.
    function void predict_render(func_e func, logic [7:0] code, logic first,
                                 logic [7:0] sx, logic [7:0] sy,
                                 logic [2:0] rpage, logic [6:0] rcol);
      int             w, pages, pg, off, c, cx;
      logic [7:0]     glyph_code, g;
      logic [39:0]    bits;
      render_result_t res;
      res = '0;
      w = eff_width();
      pages = eff_pages();
      case (func)
        FUNC_CLEAR: foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        FUNC_READ:  res.read_data = frame_bytes[int'(rpage)*FRAME_COLS + int'(rcol)];
        FUNC_DRAW: begin
          if (first) begin
            cursor_col = int'(sx);
            cursor_row = int'(sy);
            chars_taken = 0;
            string_done = 1'b0;
          end
          if (!string_done) begin
            if (code == 8'd0 || chars_taken >= STRING_LIMIT || cursor_col >= w) begin
              string_done = 1'b1;
            end else begin
              if (cursor_col < w && cursor_row < pages*8) begin
                glyph_code = (code < FIRST_CODE || code > LAST_CODE) ? FALLBACK_CODE : code;
                bits = glyph_cols[int'(glyph_code) - int'(FIRST_CODE)];
                pg = cursor_row >> 3;
                off = cursor_row & 7;
                for (c = 0; c < GLYPH_W && cursor_col + c < w; c++) begin
                  cx = cursor_col + c;
                  g = bits[39-8*c -: 8];
                  if (off != 0) begin
                    frame_bytes[pg*FRAME_COLS + cx] |= 8'(g << off);
                    if (pg + 1 < pages)
                      frame_bytes[(pg+1)*FRAME_COLS + cx] |= 8'(g >> (8 - off));
                  end else begin
                    frame_bytes[pg*FRAME_COLS + cx] |= g;
                  end
                end
              end
              res.drawn = 1'b1;
              chars_taken++;
              cursor_col = (cursor_col + advance_reg) & 255;
              if (cursor_col >= w - GLYPH_W) begin
                cursor_col = 0;
                cursor_row = (cursor_row + 8) & 255;
                if (cursor_row >= pages*8) string_done = 1'b1;
              end
              if (chars_taken >= STRING_LIMIT || cursor_col >= w) string_done = 1'b1;
            end
          end
        end
        default: ;
      endcase
      res.cursor_x = 8'(cursor_col);
      res.cursor_y = 8'(cursor_row);
      res.string_ended = string_done;
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    task compare_render(render_result_t got);
      render_result_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no transaction pending");
      end else begin
        exp = pending_results.pop_front();
        if (got.read_data !== exp.read_data)
          report_mismatch($sformatf("read_data %h, expected %h", got.read_data, exp.read_data));
        if (got.cursor_x !== exp.cursor_x)
          report_mismatch($sformatf("cursor_x %0d, expected %0d", got.cursor_x, exp.cursor_x));
        if (got.cursor_y !== exp.cursor_y)
          report_mismatch($sformatf("cursor_y %0d, expected %0d", got.cursor_y, exp.cursor_y));
        if (got.drawn !== exp.drawn)
          report_mismatch($sformatf("drawn %b, expected %b", got.drawn, exp.drawn));
        if (got.string_ended !== exp.string_ended)
          report_mismatch($sformatf("string_ended %b, expected %b",
                                    got.string_ended, exp.string_ended));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;
  logic       start;
  logic       busy;
  logic [1:0] func_i;
  logic [7:0] char_code_i;
  logic       first_i;
  logic [7:0] start_x_i;
  logic [7:0] start_y_i;
  logic [2:0] read_page_i;
  logic [6:0] read_column_i;
  logic       done_o;
  logic [7:0] read_data_o;
  logic [7:0] cursor_x_o;
  logic [7:0] cursor_y_o;
  logic       drawn_o;
  logic       string_ended_o;

  render_scoreboard sb;
  bit               idle_enabled;

  page_text_renderer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .first_i       (first_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .read_page_i   (read_page_i),
    .read_column_i (read_column_i),
    .done_o        (done_o),
    .read_data_o   (read_data_o),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .drawn_o       (drawn_o),
    .string_ended_o(string_ended_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      sb.compare_render('{read_data: read_data_o, cursor_x: cursor_x_o,
                          cursor_y: cursor_y_o, drawn: drawn_o,
                          string_ended: string_ended_o});
    end
  end

  task automatic idle_for(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic send_item(input func_e func, input logic [7:0] code, input logic first,
                           input logic [7:0] sx, input logic [7:0] sy,
                           input logic [2:0] rpage, input logic [6:0] rcol);
    if (idle_enabled && $urandom_range(99) < 20) idle_for($urandom_range(1, 14));
    @(negedge clk_i);
    start <= 1'b1;
    func_i <= func;
    char_code_i <= code;
    first_i <= first;
    start_x_i <= sx;
    start_y_i <= sy;
    read_page_i <= rpage;
    read_column_i <= rcol;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.predict_render(func, code, first, sx, sy, rpage, rcol);
  endtask

  task automatic drain();
    idle_for(1);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [7:0] w, input logic [7:0] h,
                                input logic [7:0] adv);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WIDTH;
    cfg_wdata_i <= w;
    sb.set_register(CFG_WIDTH, w);
    @(negedge clk_i);
    cfg_idx_i <= CFG_HEIGHT;
    cfg_wdata_i <= h;
    sb.set_register(CFG_HEIGHT, h);
    @(negedge clk_i);
    cfg_idx_i <= CFG_ADVANCE;
    cfg_wdata_i <= adv;
    sb.set_register(CFG_ADVANCE, adv);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_char();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'($urandom_range(1, 31));
    if (pick == 1) return 8'($urandom_range(127, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  // Mostly whole strings with random content; reads, stray characters,
  // unused codes and clears in between.
  task automatic random_strings(input int unsigned count);
    int unsigned sent, len, k, pick, w, h;
    logic [7:0]  sx, sy;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(199);
      w = sb.eff_width();
      h = sb.eff_pages() * 8;
      if (pick < 120) begin
        len = $urandom_range(1, 30);
        sx = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(w + 4));
        sy = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(h));
        send_item(FUNC_DRAW, rand_char(), 1'b1, sx, sy, 3'($urandom()), 7'($urandom()));
        for (k = 1; k < len; k++) begin
          send_item(FUNC_DRAW, rand_char(), 1'b0, 8'($urandom()), 8'($urandom()),
                    3'($urandom()), 7'($urandom()));
        end
        if ($urandom_range(3) == 0) begin
          send_item(FUNC_DRAW, 8'd0, 1'b0, 8'($urandom()), 8'($urandom()),
                    3'($urandom()), 7'($urandom()));
        end
        sent += len;
      end else if (pick < 175) begin
        send_item(FUNC_READ, 8'($urandom()), 1'($urandom()), 8'($urandom()),
                  8'($urandom()), 3'($urandom()), 7'($urandom()));
        sent++;
      end else if (pick < 192) begin
        send_item(FUNC_DRAW, 8'($urandom()), $urandom_range(9) == 0, 8'($urandom()),
                  8'($urandom()), 3'($urandom()), 7'($urandom()));
        sent++;
      end else if (pick < 196) begin
        send_item(FUNC_NOP, 8'($urandom()), 1'($urandom()), 8'($urandom()),
                  8'($urandom()), 3'($urandom()), 7'($urandom()));
      end else begin
        send_item(FUNC_CLEAR, 8'($urandom()), 1'($urandom()), 8'($urandom()),
                  8'($urandom()), 3'($urandom()), 7'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    int phase;
    sb = new();
    idle_enabled = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WIDTH;
    cfg_wdata_i = 8'd0;
    start = 1'b0;
    func_i = FUNC_NOP;
    char_code_i = 8'd0;
    first_i = 1'b0;
    start_x_i = 8'd0;
    start_y_i = 8'd0;
    read_page_i = 3'd0;
    read_column_i = 7'd0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    apply_settings(8'd128, 8'd64, 8'd6);

    send_item(FUNC_READ, 8'd0, 1'b0, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd65, 1'b1, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd103, 1'b0, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd31, 1'b0, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd127, 1'b0, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd255, 1'b0, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd0, 1'b0, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd88, 1'b0, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_READ, 8'd0, 1'b0, 8'd0, 8'd0, 3'd0, 7'd6);
    send_item(FUNC_READ, 8'hFF, 1'b1, 8'hFF, 8'hFF, 3'd7, 7'd127);
    send_item(FUNC_DRAW, 8'd103, 1'b1, 8'd10, 8'd3, 3'd0, 7'd0);
    send_item(FUNC_READ, 8'd0, 1'b0, 8'd0, 8'd0, 3'd0, 7'd11);
    send_item(FUNC_READ, 8'd0, 1'b0, 8'd0, 8'd0, 3'd1, 7'd11);
    send_item(FUNC_DRAW, 8'd106, 1'b1, 8'd20, 8'd60, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd77, 1'b1, 8'd125, 8'd16, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd66, 1'b1, 8'd5, 8'd200, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd67, 1'b1, 8'd255, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd126, 1'b1, 8'd120, 8'd56, 3'd0, 7'd0);
    send_item(FUNC_DRAW, 8'd32, 1'b1, 8'd0, 8'd8, 3'd0, 7'd0);
    send_item(FUNC_NOP, 8'd0, 1'b0, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_CLEAR, 8'd0, 1'b0, 8'd0, 8'd0, 3'd0, 7'd0);
    send_item(FUNC_READ, 8'd0, 1'b0, 8'd0, 8'd0, 3'd1, 7'd11);
    send_item(FUNC_DRAW, 8'd0, 1'b1, 8'd0, 8'd0, 3'd0, 7'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        apply_settings(8'(PHASE_WIDTH[phase]), 8'(PHASE_HEIGHT[phase]),
                       8'(PHASE_ADVANCE[phase]));
        send_item(FUNC_CLEAR, 8'($urandom()), 1'($urandom()), 8'($urandom()),
                  8'($urandom()), 3'($urandom()), 7'($urandom()));
      end
      idle_enabled = (phase != 3);
      random_strings(PHASE_ITEMS);
    end
    drain();

    if (sb.mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
